// ----- hw/rtl/lbc_pkg.sv -----
package lbc_pkg;

    // buffer count and the number of entries actually used (entry fields are 4 bits)
    localparam int NUM_BUFFERS = 16;
    localparam int NB          = (NUM_BUFFERS > 16) ? 16 : NUM_BUFFERS;
    localparam int EW          = $clog2(NB);

    // field widths
    localparam int REQ_W  = 2;
    localparam int DEV_W  = 8;
    localparam int BLK_W  = 32;
    localparam int IDX_W  = 4;
    localparam int STAT_W = 3;
    localparam int CMD_W  = 2;
    localparam int TAG_W  = DEV_W + BLK_W;

    // request codes
    localparam logic [REQ_W-1:0] REQ_READ    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STAT_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STAT_W-1:0] ST_RETRY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_FREE  = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_HELD = 3'd4;

    // disk command codes
    localparam logic [CMD_W-1:0] IO_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] IO_READ  = 2'd1;
    localparam logic [CMD_W-1:0] IO_WRITE = 2'd2;

    typedef logic [EW-1:0]  t_ptr;
    typedef logic [TAG_W-1:0] t_tag;

endpackage

// ----- hw/rtl/lru_block_buffer_cache.sv -----
// Tag and control part of an LRU disk-block buffer cache. A request is taken when start is
// high and busy is low, and exactly one result comes back on o_valid for one cycle; the
// receiver cannot stall it, so it must take every result as it appears. A read request walks
// the tag store one entry per cycle through a single tag comparator fed from the tag memory's
// registered read port: it scans all NB entries (the first tag is fetched at the accepting
// edge), then picks and updates the entry in S_FIN, and the result is registered onto the
// ports. Write and release requests, and unknown codes, go through S_EXEC, whose result is
// registered onto the ports the same way. busy drops in the cycle the result appears, so the
// next request may be accepted then. A read that hits a held entry answers busy retry and
// the requester issues it again later; io_device and io_block are zero whenever no disk
// command is issued.
module lru_block_buffer_cache
    import lbc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [DEV_W-1:0]  i_device_id,
    input  logic [BLK_W-1:0]  i_block_number,
    input  logic [IDX_W-1:0]  i_entry_index,
    output logic              o_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [IDX_W-1:0]  o_granted_entry,
    output logic [CMD_W-1:0]  o_io_command,
    output logic [DEV_W-1:0]  o_io_device,
    output logic [BLK_W-1:0]  o_io_block
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_EXEC = 2'd3;

    localparam t_ptr LAST_PTR = t_ptr'(NB - 1);

    logic [1:0]        r_state, n_state;
    t_ptr              r_ptr, n_ptr;
    logic [REQ_W-1:0]  r_req, n_req;
    logic [DEV_W-1:0]  r_dev, n_dev;
    logic [BLK_W-1:0]  r_blk, n_blk;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_idx_ok, n_idx_ok;

    // per-entry state
    logic [NB-1:0]     r_present, n_present;
    logic [NB-1:0]     r_ebusy, n_ebusy;
    logic [NB-1:0]     r_evalid, n_evalid;
    logic [NB-1:0]     r_edirty, n_edirty;
    t_ptr              r_rank [NB];
    t_ptr              n_rank [NB];

    // scan candidates
    logic              r_hit_found, n_hit_found;
    t_ptr              r_hit_sel, n_hit_sel;
    t_ptr              r_hit_rank, n_hit_rank;
    logic              r_vic_found, n_vic_found;
    t_ptr              r_vic_sel, n_vic_sel;
    t_ptr              r_vic_rank, n_vic_rank;

    // result registers
    logic              r_valid, n_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic [IDX_W-1:0]  r_gnt, n_gnt;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [DEV_W-1:0]  r_io_dev, n_io_dev;
    logic [BLK_W-1:0]  r_io_blk, n_io_blk;

    // tag memory, one registered read port
    t_tag              r_tag_mem [NB];
    t_tag              r_tag_q;
    logic              mem_we;
    t_ptr              mem_waddr;

    logic              in_range;
    logic              tag_match;
    logic              entry_free;

    assign in_range   = ({1'b0, i_entry_index} < 5'(NB));
    assign tag_match  = r_present[r_ptr] && (r_tag_q == {r_dev, r_blk});
    assign entry_free = !r_ebusy[r_ptr] && !r_edirty[r_ptr];

    // sequencer and entry update
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_req       = r_req;
        n_dev       = r_dev;
        n_blk       = r_blk;
        n_idx       = r_idx;
        n_idx_ok    = r_idx_ok;
        n_present   = r_present;
        n_ebusy     = r_ebusy;
        n_evalid    = r_evalid;
        n_edirty    = r_edirty;
        n_rank      = r_rank;
        n_hit_found = r_hit_found;
        n_hit_sel   = r_hit_sel;
        n_hit_rank  = r_hit_rank;
        n_vic_found = r_vic_found;
        n_vic_sel   = r_vic_sel;
        n_vic_rank  = r_vic_rank;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_gnt       = r_gnt;
        n_cmd       = r_cmd;
        n_io_dev    = r_io_dev;
        n_io_blk    = r_io_blk;
        mem_we      = 1'b0;
        mem_waddr   = r_vic_sel;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req       = i_req_type;
                    n_dev       = i_device_id;
                    n_blk       = i_block_number;
                    n_idx       = i_entry_index;
                    n_idx_ok    = in_range;
                    n_hit_found = 1'b0;
                    n_vic_found = 1'b0;
                    if (i_req_type == REQ_READ) begin
                        n_ptr   = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_ptr   = in_range ? i_entry_index[EW-1:0] : '0;
                        n_state = S_EXEC;
                    end
                end
            end

            // one entry per cycle through the shared tag comparator
            S_SCAN: begin
                if (tag_match && (!r_hit_found || r_rank[r_ptr] > r_hit_rank)) begin
                    n_hit_found = 1'b1;
                    n_hit_sel   = r_ptr;
                    n_hit_rank  = r_rank[r_ptr];
                end
                if (entry_free && (!r_vic_found || r_rank[r_ptr] < r_vic_rank)) begin
                    n_vic_found = 1'b1;
                    n_vic_sel   = r_ptr;
                    n_vic_rank  = r_rank[r_ptr];
                end
                if (r_ptr == LAST_PTR) begin
                    n_state = S_FIN;
                end else begin
                    n_ptr = r_ptr + t_ptr'(1);
                end
            end

            // read request outcome
            S_FIN: begin
                n_valid  = 1'b1;
                n_state  = S_IDLE;
                n_cmd    = IO_NONE;
                n_io_dev = '0;
                n_io_blk = '0;
                if (r_hit_found) begin
                    n_gnt = IDX_W'(r_hit_sel);
                    if (r_ebusy[r_hit_sel]) begin
                        n_status = ST_RETRY;
                    end else begin
                        n_status            = ST_HIT;
                        n_ebusy[r_hit_sel]  = 1'b1;
                        if (!r_evalid[r_hit_sel]) begin
                            n_evalid[r_hit_sel] = 1'b1;
                            n_cmd    = IO_READ;
                            n_io_dev = r_dev;
                            n_io_blk = r_blk;
                        end
                    end
                end else if (r_vic_found) begin
                    mem_we               = 1'b1;
                    n_present[r_vic_sel] = 1'b1;
                    n_ebusy[r_vic_sel]   = 1'b1;
                    n_evalid[r_vic_sel]  = 1'b1;
                    n_edirty[r_vic_sel]  = 1'b0;
                    n_status = ST_MISS;
                    n_gnt    = IDX_W'(r_vic_sel);
                    n_cmd    = IO_READ;
                    n_io_dev = r_dev;
                    n_io_blk = r_blk;
                end else begin
                    n_status = ST_NO_FREE;
                    n_gnt    = '0;
                end
            end

            // write, release and unknown requests
            S_EXEC: begin
                n_valid  = 1'b1;
                n_state  = S_IDLE;
                n_cmd    = IO_NONE;
                n_io_dev = '0;
                n_io_blk = '0;
                if (r_req != REQ_WRITE && r_req != REQ_RELEASE) begin
                    n_status = ST_NOT_HELD;
                    n_gnt    = '0;
                end else if (!r_idx_ok || !r_ebusy[r_ptr]) begin
                    n_status = ST_NOT_HELD;
                    n_gnt    = r_idx;
                end else if (r_req == REQ_WRITE) begin
                    n_evalid[r_ptr] = 1'b1;
                    n_edirty[r_ptr] = 1'b0;
                    n_status = ST_HIT;
                    n_gnt    = r_idx;
                    n_cmd    = IO_WRITE;
                    n_io_dev = r_tag_q[TAG_W-1:BLK_W];
                    n_io_blk = r_tag_q[BLK_W-1:0];
                end else begin
                    for (int i = 0; i < NB; i++) begin
                        if (r_rank[i] > r_rank[r_ptr]) begin
                            n_rank[i] = r_rank[i] - t_ptr'(1);
                        end
                    end
                    n_rank[r_ptr]  = LAST_PTR;
                    n_ebusy[r_ptr] = 1'b0;
                    n_status = ST_HIT;
                    n_gnt    = r_idx;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and entry state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= 1'b0;
            r_present   <= '0;
            r_ebusy     <= '0;
            r_evalid    <= '0;
            r_edirty    <= '0;
            r_hit_found <= 1'b0;
            r_vic_found <= 1'b0;
            r_ptr       <= '0;
            for (int i = 0; i < NB; i++) begin
                r_rank[i] <= t_ptr'(i);
            end
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_present   <= n_present;
            r_ebusy     <= n_ebusy;
            r_evalid    <= n_evalid;
            r_edirty    <= n_edirty;
            r_hit_found <= n_hit_found;
            r_vic_found <= n_vic_found;
            r_ptr       <= n_ptr;
            r_rank      <= n_rank;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_dev      <= n_dev;
        r_blk      <= n_blk;
        r_idx      <= n_idx;
        r_idx_ok   <= n_idx_ok;
        r_hit_sel  <= n_hit_sel;
        r_hit_rank <= n_hit_rank;
        r_vic_sel  <= n_vic_sel;
        r_vic_rank <= n_vic_rank;
        r_status   <= n_status;
        r_gnt      <= n_gnt;
        r_cmd      <= n_cmd;
        r_io_dev   <= n_io_dev;
        r_io_blk   <= n_io_blk;
    end

    // tag memory, read address follows the next scan pointer
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tag_mem[mem_waddr] <= {r_dev, r_blk};
        end
        r_tag_q <= r_tag_mem[n_ptr];
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_granted_entry = r_gnt;
    assign o_io_command    = r_cmd;
    assign o_io_device     = r_io_dev;
    assign o_io_block      = r_io_blk;

    // ranks stay a permutation of all entry positions
    logic [NB-1:0] rank_seen;
    always_comb begin
        rank_seen = '0;
        for (int i = 0; i < NB; i++) begin
            rank_seen[r_rank[i]] = 1'b1;
        end
    end

    a_rank_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &rank_seen)
        else $error("recency ranks are not a permutation");

    a_busy_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ebusy & ~r_present) == '0)
        else $error("held entry without a tag");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a transaction in progress");

    a_no_cmd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_io_command == IO_NONE) |-> (o_io_device == '0 && o_io_block == '0))
        else $error("disk fields set without a command");

    a_miss_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_MISS) |-> (o_io_command == IO_READ))
        else $error("miss fill without a disk read");

endmodule
